// ===== sv/protobuf_frame_parser_assert.svh =====
// Assertion macros used by the frame parser queue module.
// Each macro expects i_clk and i_rst_n to be visible in the using module.
`ifndef PROTOBUF_FRAME_PARSER_ASSERT_SVH
`define PROTOBUF_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PFP_ASSERT(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("pfp assertion failed");

// Next-cycle implication, checked outside reset.
`define PFP_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("pfp assertion failed");

`endif

// ===== sv/pfp_pkg.sv =====
// Package for the protobuf frame parser: sizes, codes, record types, helpers.
// Used by every module of the block; depends on nothing.
package pfp_pkg;

    localparam int MAX_HEADERS = 8;
    localparam int KEY_BYTES   = 64;
    localparam int LEN_BITS    = 32;

    localparam int HCW = $clog2(MAX_HEADERS + 1);
    localparam int SCW = $clog2(KEY_BYTES);
    localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LEN_BITS);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Protobuf wire types.
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_I64    = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_I32    = 3'd5;

    // Top-level field numbers with a meaning.
    localparam logic [31:0] FLD_HEADER  = 32'd5;
    localparam logic [31:0] FLD_PAYLOAD = 32'd8;

    // Varint byte limit index (tenth byte).
    localparam logic [3:0] VARINT_LAST = 4'd9;

    typedef enum logic [2:0] {
        KIND_SCALAR    = 3'd0,
        KIND_HDR_START = 3'd1,
        KIND_HDR_BYTE  = 3'd2,
        KIND_PAY_START = 3'd3,
        KIND_PAY_BYTE  = 3'd4,
        KIND_DONE      = 3'd5,
        KIND_ERROR     = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        OP_TAG,
        OP_VALUE,
        OP_LENGTH,
        OP_SPAN
    } t_outer;

    typedef enum logic [2:0] {
        IP_TAG,
        IP_SKIPVAR,
        IP_LENGTH,
        IP_STRING,
        IP_SKIPBYTES,
        IP_DEAD
    } t_inner;

    // One decoded event.
    typedef struct packed {
        t_kind       kind;
        logic [2:0]  fnum;
        logic [63:0] value;
        logic [2:0]  slot;
        logic        part;
        logic [7:0]  data;
    } t_event;

    // All results caused by one input byte: an event, then done or error.
    typedef struct packed {
        logic       ev_vld;
        t_event     ev;
        logic       end_vld;
        logic       end_err;
        logic [3:0] seen;
    } t_rec;

    // Place the low seven bits of a varint byte at group position cnt.
    function automatic logic [63:0] vshift(input logic [7:0] b, input logic [3:0] cnt);
        logic [63:0] x;
        logic [6:0]  amt;
        x   = {57'd0, b[6:0]};
        amt = 7'(cnt) * 7'd7;
        return x << amt;
    endfunction

endpackage

// ===== sv/protobuf_frame_parser.sv =====
// Top level of the protobuf frame parser: front end, record queue, back end.
// Depends on pfp_pkg, pfp_front, pfp_queue and pfp_back.
//
//  Channel | Handshake                | Payload
//  input   | i_in_valid / o_in_ready  | i_in_byte, i_end_of_frame
//  output  | o_out_valid / i_out_ready| o_kind ... o_last_of_run
//
// One byte is taken per cycle while the queue is not full; the byte is decoded
// in the cycle it is taken. Each byte makes at most one record, which the back
// end sends as one or two transfers, so a byte that ends a frame after an event
// yields two transfers. A four-record queue lets input continue while the
// output stalls. Reset is synchronous; input ready is held low during reset
// and is high in the first cycle after reset is released.
module protobuf_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_frame,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_field_number,
    output logic [63:0] o_scalar_value,
    output logic [2:0]  o_header_slot,
    output logic        o_string_part,
    output logic [7:0]  o_data_byte,
    output logic [3:0]  o_headers_seen,
    output logic        o_last_of_run
);
    import pfp_pkg::*;

    logic   take, push, full, pop, empty;
    t_rec   f_rec, q_rec;
    t_event ev;

    assign o_in_ready = !full && i_rst_n;
    assign take       = i_in_valid && o_in_ready;

    pfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_in_byte),
        .i_eof   (i_end_of_frame),
        .o_push  (push),
        .o_rec   (f_rec)
    );

    pfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (f_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_rec   (q_rec),
        .o_empty (empty)
    );

    pfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (q_rec),
        .i_empty (empty),
        .o_pop   (pop),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_ev    (ev),
        .o_seen  (o_headers_seen),
        .o_last  (o_last_of_run)
    );

    assign o_kind         = ev.kind;
    assign o_field_number = ev.fnum;
    assign o_scalar_value = ev.value;
    assign o_header_slot  = ev.slot;
    assign o_string_part  = ev.part;
    assign o_data_byte    = ev.data;

endmodule

// ===== sv/pfp_front.sv =====
// Front end of the frame parser: takes bytes, runs the wire-format decoder,
// and produces at most one result record per byte. Depends on pfp_pkg.
module pfp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_byte,
    input  logic          i_eof,
    output logic          o_push,
    output pfp_pkg::t_rec o_rec
);
    import pfp_pkg::*;

    t_outer                r_ophase, n_ophase;
    logic [63:0]           r_acc, n_acc;
    logic [3:0]            r_shift, n_shift;
    logic [31:0]           r_field, n_field;
    logic [2:0]            r_wt, n_wt;
    logic [LEN_BITS-1:0]   r_span, n_span;
    t_inner                r_iphase, n_iphase;
    logic [63:0]           r_iacc, n_iacc;
    logic [3:0]            r_ishift, n_ishift;
    logic [LEN_BITS-1:0]   r_ileft, n_ileft;
    logic [31:0]           r_ifield, n_ifield;
    logic [SCW-1:0]        r_scount, n_scount;
    logic [HCW-1:0]        r_hcount, n_hcount;
    logic                  r_hact, n_hact;
    logic [HCW-1:0]        r_slot, n_slot;
    logic                  r_err, n_err;

    logic [63:0]         acc_new, iacc_new;
    logic                vdone, vlong, idone, ilong;
    logic [LEN_BITS-1:0] span_dec, ileft_dec;
    logic                fail;
    t_rec                rec;

    // Varint accumulation for the outer and the inner decoder.
    always_comb begin
        acc_new  = r_acc | vshift(i_byte, r_shift);
        vdone    = !i_byte[7];
        vlong    = i_byte[7] && (r_shift >= VARINT_LAST);
        iacc_new = r_iacc | vshift(i_byte, r_ishift);
        idone    = !i_byte[7];
        ilong    = i_byte[7] && (r_ishift >= VARINT_LAST);
        span_dec  = r_span - LEN_BITS'(1);
        ileft_dec = r_ileft - LEN_BITS'(1);
    end

    // Decoder next state and the event of this byte.
    always_comb begin
        n_ophase = r_ophase; n_acc = r_acc; n_shift = r_shift; n_field = r_field;
        n_wt = r_wt; n_span = r_span; n_iphase = r_iphase; n_iacc = r_iacc;
        n_ishift = r_ishift; n_ileft = r_ileft; n_ifield = r_ifield;
        n_scount = r_scount; n_hcount = r_hcount; n_hact = r_hact; n_slot = r_slot;
        n_err = r_err;
        fail = 1'b0;
        rec  = '0;
        rec.ev.kind = KIND_SCALAR;

        if (!r_err) begin
            case (r_ophase)
                OP_TAG, OP_VALUE, OP_LENGTH: begin
                    n_acc   = acc_new;
                    n_shift = vdone ? 4'd0 : r_shift + 4'd1;
                    if (vlong) begin
                        fail = 1'b1;
                    end else if (vdone) begin
                        n_acc = '0;
                        if (r_ophase == OP_TAG) begin
                            n_field = acc_new[34:3];
                            n_wt    = acc_new[2:0];
                            case (acc_new[2:0])
                                WT_VARINT: n_ophase = OP_VALUE;
                                WT_LEN:    n_ophase = OP_LENGTH;
                                WT_I64: begin
                                    n_span   = LEN_BITS'(8);
                                    n_ophase = OP_SPAN;
                                end
                                WT_I32: begin
                                    n_span   = LEN_BITS'(4);
                                    n_ophase = OP_SPAN;
                                end
                                default: fail = 1'b1;
                            endcase
                        end else if (r_ophase == OP_VALUE) begin
                            n_ophase = OP_TAG;
                            if (r_field >= 32'd1 && r_field <= 32'd4) begin
                                rec.ev_vld   = 1'b1;
                                rec.ev.kind  = KIND_SCALAR;
                                rec.ev.fnum  = 3'(r_field);
                                rec.ev.value = (r_field >= 32'd3) ?
                                               {32'd0, acc_new[31:0]} : acc_new;
                            end
                        end else begin
                            // Length of a delimited field.
                            if (acc_new > LEN_MASK) begin
                                fail = 1'b1;
                            end else begin
                                if (r_field == FLD_HEADER) begin
                                    n_hact = r_hcount < HCW'(MAX_HEADERS);
                                    if (r_hcount < HCW'(MAX_HEADERS)) begin
                                        n_slot   = r_hcount;
                                        n_hcount = r_hcount + HCW'(1);
                                        n_iphase = IP_TAG;
                                        n_iacc   = '0;
                                        n_ishift = '0;
                                        n_ileft  = '0;
                                    end
                                end else if (r_field == FLD_PAYLOAD) begin
                                    rec.ev_vld   = 1'b1;
                                    rec.ev.kind  = KIND_PAY_START;
                                    rec.ev.value = acc_new;
                                end
                                n_span   = acc_new[LEN_BITS-1:0];
                                n_ophase = (acc_new != 64'd0) ? OP_SPAN : OP_TAG;
                            end
                        end
                    end
                end
                OP_SPAN: begin
                    n_span = span_dec;
                    if (span_dec == '0) begin
                        n_ophase = OP_TAG;
                    end
                    if (r_wt == WT_LEN && r_field == FLD_HEADER && r_hact) begin
                        // Header sub-message decoder.
                        case (r_iphase)
                            IP_TAG, IP_SKIPVAR, IP_LENGTH: begin
                                n_iacc   = iacc_new;
                                n_ishift = idone ? 4'd0 : r_ishift + 4'd1;
                                if (ilong) begin
                                    n_iphase = IP_DEAD;
                                end else if (idone) begin
                                    n_iacc = '0;
                                    if (r_iphase == IP_TAG) begin
                                        n_ifield = iacc_new[34:3];
                                        case (iacc_new[2:0])
                                            WT_LEN:    n_iphase = IP_LENGTH;
                                            WT_VARINT: n_iphase = IP_SKIPVAR;
                                            WT_I64: begin
                                                n_ileft  = LEN_BITS'(8);
                                                n_iphase = (span_dec < LEN_BITS'(8)) ?
                                                           IP_DEAD : IP_SKIPBYTES;
                                            end
                                            WT_I32: begin
                                                n_ileft  = LEN_BITS'(4);
                                                n_iphase = (span_dec < LEN_BITS'(4)) ?
                                                           IP_DEAD : IP_SKIPBYTES;
                                            end
                                            default: n_iphase = IP_DEAD;
                                        endcase
                                    end else if (r_iphase == IP_SKIPVAR) begin
                                        n_iphase = IP_TAG;
                                    end else if (iacc_new > 64'(span_dec)) begin
                                        n_iphase = IP_DEAD;
                                    end else begin
                                        n_ileft = iacc_new[LEN_BITS-1:0];
                                        if (r_ifield == 32'd1 || r_ifield == 32'd2) begin
                                            rec.ev_vld   = 1'b1;
                                            rec.ev.kind  = KIND_HDR_START;
                                            rec.ev.value = iacc_new;
                                            rec.ev.slot  = 3'(r_slot);
                                            rec.ev.part  = (r_ifield == 32'd2);
                                            n_scount     = '0;
                                        end
                                        if (iacc_new == 64'd0) begin
                                            n_iphase = IP_TAG;
                                        end else if (r_ifield == 32'd1 ||
                                                     r_ifield == 32'd2) begin
                                            n_iphase = IP_STRING;
                                        end else begin
                                            n_iphase = IP_SKIPBYTES;
                                        end
                                    end
                                end
                            end
                            IP_STRING: begin
                                if (r_scount < SCW'(KEY_BYTES - 1)) begin
                                    rec.ev_vld  = 1'b1;
                                    rec.ev.kind = KIND_HDR_BYTE;
                                    rec.ev.slot = 3'(r_slot);
                                    rec.ev.part = (r_ifield == 32'd2);
                                    rec.ev.data = i_byte;
                                    n_scount    = r_scount + SCW'(1);
                                end
                                n_ileft = ileft_dec;
                                if (ileft_dec == '0) begin
                                    n_iphase = IP_TAG;
                                end
                            end
                            IP_SKIPBYTES: begin
                                n_ileft = ileft_dec;
                                if (ileft_dec == '0) begin
                                    n_iphase = IP_TAG;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end else if (r_wt == WT_LEN && r_field == FLD_PAYLOAD) begin
                        rec.ev_vld  = 1'b1;
                        rec.ev.kind = KIND_PAY_BYTE;
                        rec.ev.data = i_byte;
                    end
                end
                default: begin
                end
            endcase

            // Frame-level outcome of this byte.
            if (fail) begin
                n_err       = 1'b1;
                rec.ev_vld  = 1'b0;
                rec.end_vld = 1'b1;
                rec.end_err = 1'b1;
            end else if (i_eof) begin
                rec.end_vld = 1'b1;
                rec.end_err = (n_ophase != OP_TAG);
                rec.seen    = rec.end_err ? 4'd0 : 4'(n_hcount);
            end
        end
    end

    assign o_rec  = rec;
    assign o_push = i_take && (rec.ev_vld || rec.end_vld);

    // Decoder state; the end of a frame returns everything to reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_eof)) begin
            r_ophase <= OP_TAG;  r_acc <= '0;    r_shift <= '0;  r_field <= '0;
            r_wt <= '0;          r_span <= '0;   r_iphase <= IP_TAG;
            r_iacc <= '0;        r_ishift <= '0; r_ileft <= '0;  r_ifield <= '0;
            r_scount <= '0;      r_hcount <= '0; r_hact <= 1'b0; r_slot <= '0;
            r_err <= 1'b0;
        end else if (i_take) begin
            r_ophase <= n_ophase; r_acc <= n_acc;     r_shift <= n_shift;
            r_field <= n_field;   r_wt <= n_wt;       r_span <= n_span;
            r_iphase <= n_iphase; r_iacc <= n_iacc;   r_ishift <= n_ishift;
            r_ileft <= n_ileft;   r_ifield <= n_ifield;
            r_scount <= n_scount; r_hcount <= n_hcount; r_hact <= n_hact;
            r_slot <= n_slot;     r_err <= n_err;
        end
    end

endmodule

// ===== sv/pfp_queue.sv =====
// Short record queue between the parser front end and the result back end.
// Depends on pfp_pkg and the assertion macro header.
module pfp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pfp_pkg::t_rec i_rec,
    output logic          o_full,
    input  logic          i_pop,
    output pfp_pkg::t_rec o_rec,
    output logic          o_empty
);
    import pfp_pkg::*;
    `include "protobuf_frame_parser_assert.svh"

    t_rec           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rec   = r_mem[r_rp];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    `PFP_ASSERT(a_no_overflow, i_push, !o_full || i_pop)
    `PFP_ASSERT(a_no_underflow, i_pop, !o_empty)
    `PFP_ASSERT(a_cnt_range, 1'b1, r_cnt <= (QAW+1)'(QDEPTH))
    `PFP_ASSERT_NEXT(a_cnt_up, i_push && !i_pop, r_cnt == $past(r_cnt) + (QAW+1)'(1))

endmodule

// ===== sv/pfp_back.sv =====
// Back end of the frame parser: splits each record into result transfers
// and holds them in the output register. Depends on pfp_pkg.
module pfp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pfp_pkg::t_rec i_rec,
    input  logic          i_empty,
    output logic          o_pop,
    input  logic          i_ready,
    output logic          o_valid,
    output pfp_pkg::t_event o_ev,
    output logic [3:0]    o_seen,
    output logic          o_last
);
    import pfp_pkg::*;

    logic   r_vld, n_vld;
    logic   r_sub, n_sub;
    t_event r_ev, n_ev;
    logic [3:0] r_seen, n_seen;
    logic   r_last, n_last;
    logic   load;

    // Select the next result from the queue head.
    always_comb begin
        load  = !r_vld || i_ready;
        n_vld = r_vld; n_sub = r_sub; n_ev = r_ev; n_seen = r_seen; n_last = r_last;
        o_pop = 1'b0;
        if (load) begin
            n_vld = !i_empty;
            if (!i_empty) begin
                if (i_rec.ev_vld && !r_sub) begin
                    n_ev   = i_rec.ev;
                    n_seen = 4'd0;
                    n_last = !i_rec.end_vld;
                    n_sub  = i_rec.end_vld;
                    o_pop  = !i_rec.end_vld;
                end else begin
                    n_ev      = '0;
                    n_ev.kind = i_rec.end_err ? KIND_ERROR : KIND_DONE;
                    n_seen    = i_rec.seen;
                    n_last    = 1'b1;
                    n_sub     = 1'b0;
                    o_pop     = 1'b1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_sub <= 1'b0;
        end else begin
            r_vld <= n_vld;
            r_sub <= n_sub;
        end
        r_ev   <= n_ev;
        r_seen <= n_seen;
        r_last <= n_last;
    end

    assign o_valid = r_vld;
    assign o_ev    = r_ev;
    assign o_seen  = r_seen;
    assign o_last  = r_last;

endmodule
